// File: hw/rtl/tlmax_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlmax_pkg
// Shared types and constants for the thresholded 3x3 local-maximum core.
// ----------------------------------------------------------------------------
package tlmax_pkg;

  // Line store geometry.
  localparam int MaxWidth    = 1024;
  localparam int AddrBits    = $clog2(MaxWidth);
  localparam int MaxHeight   = 4096;
  localparam int SampleBits  = 16;

  // Field widths of the stream and register interfaces.
  localparam int ColBits     = 10;
  localparam int RowBits     = 12;
  localparam int WidthBits   = 11;
  localparam int HeightBits  = 13;
  localparam int CfgDataBits = 16;
  localparam int CfgIdxBits  = 2;

  // Clamp limits and reset values of the registers.
  localparam logic [WidthBits-1:0]  WidthMin    = WidthBits'(3);
  localparam logic [WidthBits-1:0]  WidthMax    = WidthBits'(MaxWidth);
  localparam logic [HeightBits-1:0] HeightMin   = HeightBits'(3);
  localparam logic [HeightBits-1:0] HeightMax   = HeightBits'(MaxHeight);
  localparam logic [WidthBits-1:0]  WidthRst    = WidthBits'(640);
  localparam logic [HeightBits-1:0] HeightRst   = HeightBits'(480);
  // 0.135 in Q2.14, rounded to the nearest code.
  localparam logic [SampleBits-1:0] ThresholdRst = SampleBits'(2212);

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxBits-1:0] {
    CfgImageWidth      = 2'd0,
    CfgImageHeight     = 2'd1,
    CfgCornerThreshold = 2'd2
  } cfg_reg_e;

  typedef logic signed [SampleBits-1:0] sample_t;

  // One input beat.
  typedef struct packed {
    sample_t response_value;
    logic    frame_start;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [ColBits-1:0] centre_x;
    logic [RowBits-1:0] centre_y;
    logic               is_corner;
  } out_beat_t;

  // Raster position of a pixel.
  typedef struct packed {
    logic [ColBits-1:0] x;
    logic [RowBits-1:0] y;
  } pos_t;

  // One line store entry: row y-1 and row y-2 of one column.
  typedef struct packed {
    sample_t row_a;
    sample_t row_b;
  } lb_word_t;

  // Access control of the line store.
  typedef struct packed {
    logic                rd_en;
    logic [AddrBits-1:0] rd_addr;
    logic                wr_en;
    logic [AddrBits-1:0] wr_addr;
  } lb_ctrl_t;

  // One column of the 3x3 window, top row first.
  typedef struct packed {
    sample_t top;
    sample_t mid;
    sample_t bot;
  } col_t;

endpackage
`default_nettype wire

// File: hw/rtl/tlmax_pos.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlmax_pos
// Raster position counters with frame-start restart and clamped frame size.
// ----------------------------------------------------------------------------
module tlmax_pos (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                accept_i,
  input  wire logic                                frame_start_i,
  input  wire logic [tlmax_pkg::WidthBits-1:0]     width_i,
  input  wire logic [tlmax_pkg::HeightBits-1:0]    height_i,
  output tlmax_pkg::pos_t                          pos_o
);

  logic [tlmax_pkg::ColBits-1:0]    col_q, col_d;
  logic [tlmax_pkg::RowBits-1:0]    row_q, row_d;
  logic [tlmax_pkg::WidthBits-1:0]  eff_width;
  logic [tlmax_pkg::HeightBits-1:0] eff_height;
  logic [tlmax_pkg::WidthBits-1:0]  col_inc;
  logic [tlmax_pkg::HeightBits-1:0] row_inc;

  // Position of the beat at the input: a frame start restarts at the origin.
  assign pos_o.x = frame_start_i ? '0 : col_q;
  assign pos_o.y = frame_start_i ? '0 : row_q;

  // Out-of-range frame sizes act as the nearest legal size.
  always_comb begin
    if (width_i < tlmax_pkg::WidthMin) begin
      eff_width = tlmax_pkg::WidthMin;
    end else if (width_i > tlmax_pkg::WidthMax) begin
      eff_width = tlmax_pkg::WidthMax;
    end else begin
      eff_width = width_i;
    end
    if (height_i < tlmax_pkg::HeightMin) begin
      eff_height = tlmax_pkg::HeightMin;
    end else if (height_i > tlmax_pkg::HeightMax) begin
      eff_height = tlmax_pkg::HeightMax;
    end else begin
      eff_height = height_i;
    end
  end

  // Advance in raster order, wrapping at the end of a row and of the frame.
  always_comb begin
    col_inc = {1'b0, pos_o.x} + tlmax_pkg::WidthBits'(1);
    row_inc = {1'b0, pos_o.y} + tlmax_pkg::HeightBits'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept_i) begin
      if (col_inc >= eff_width) begin
        col_d = '0;
        row_d = (row_inc >= eff_height) ? '0 : row_inc[tlmax_pkg::RowBits-1:0];
      end else begin
        col_d = col_inc[tlmax_pkg::ColBits-1:0];
        row_d = pos_o.y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tlmax_lbuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlmax_lbuf
// Line store of the two previous rows, one entry per column, with forwarding
// of a write that lands on the address read in the same cycle.
// ----------------------------------------------------------------------------
module tlmax_lbuf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tlmax_pkg::lb_ctrl_t  ctrl_i,
  input  wire tlmax_pkg::lb_word_t  wr_data_i,
  output tlmax_pkg::lb_word_t       rd_data_o
);

  tlmax_pkg::lb_word_t mem [tlmax_pkg::MaxWidth];
  tlmax_pkg::lb_word_t rd_q;
  tlmax_pkg::lb_word_t fwd_data_q;
  logic                fwd_q, fwd_d;

  // Synchronous memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.wr_addr] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem[ctrl_i.rd_addr];
    end
  end

  // A read that meets a write to the same entry sees the new data.
  assign fwd_d = ctrl_i.wr_en && (ctrl_i.wr_addr == ctrl_i.rd_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (ctrl_i.rd_en) begin
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule
`default_nettype wire

// File: hw/rtl/tlmax_nms.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlmax_nms
// 3x3 window registers and the local-maximum and threshold decision.
// ----------------------------------------------------------------------------
module tlmax_nms (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                shift_i,
  input  wire tlmax_pkg::col_t     col_i,
  input  wire tlmax_pkg::sample_t  threshold_i,
  output logic                     is_corner_o
);

  // Window columns x-2 and x-1; column x arrives on col_i.
  tlmax_pkg::col_t    win_old_q;
  tlmax_pkg::col_t    win_mid_q;
  tlmax_pkg::sample_t centre;
  logic               is_max;

  assign centre = win_mid_q.mid;

  // Ties count as maxima, so the centre only has to be no smaller.
  always_comb begin
    is_max = (centre >= win_old_q.top) && (centre >= win_old_q.mid) &&
             (centre >= win_old_q.bot) && (centre >= win_mid_q.top) &&
             (centre >= win_mid_q.bot) && (centre >= col_i.top) &&
             (centre >= col_i.mid) && (centre >= col_i.bot);
  end

  assign is_corner_o = is_max && (centre > threshold_i);

  // Slide the window by one column per processed beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_old_q <= '0;
      win_mid_q <= '0;
    end else if (shift_i) begin
      win_old_q <= win_mid_q;
      win_mid_q <= col_i;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/threshold_local_max_3x3_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_local_max_3x3_core
// Thresholded 3x3 non-maximum suppression over a raster stream of Q2.14
// corner responses.
// ----------------------------------------------------------------------------
// The core takes one sample per clock unless stalled and, for every interior
// pixel, gives one registered result beat after the beat that completes its
// 3x3 window; border pixels produce no beat. The rate of one beat per cycle
// is set by the line store, a 1024 x 32 synchronous memory that is read and
// written once per beat; a write that hits the entry being read in the same
// cycle is forwarded. Back-pressure from the result side holds the
// processing stage and stalls the input. The line store is not cleared: each
// entry must be written in the current frame before it is read as a
// neighbor, which holds as long as image_width stays fixed within a frame.
// Configuration is to be written only while the core is idle.
// ----------------------------------------------------------------------------
module threshold_local_max_3x3_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Configuration write port.
  input  wire logic                                  cfg_we_i,
  input  wire logic [tlmax_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  wire logic [tlmax_pkg::CfgDataBits-1:0]     cfg_data_i,
  // Sample stream.
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire tlmax_pkg::in_beat_t                   in_data_i,
  // Result stream.
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output tlmax_pkg::out_beat_t                       out_data_o
);

  // Configuration registers.
  logic [tlmax_pkg::WidthBits-1:0]  width_q;
  logic [tlmax_pkg::HeightBits-1:0] height_q;
  tlmax_pkg::sample_t               threshold_q;

  // Processing stage, aligned with the line store read data.
  logic                             s1_valid_q, s1_valid_d;
  tlmax_pkg::pos_t                  s1_pos_q;
  tlmax_pkg::sample_t               s1_sample_q;
  logic                             s1_go;

  // Result register.
  logic                             out_valid_q, out_valid_d;
  tlmax_pkg::out_beat_t             out_data_q;

  logic                             accept;
  logic                             emit;
  logic                             is_corner;
  tlmax_pkg::pos_t                  in_pos;
  tlmax_pkg::lb_ctrl_t              lb_ctrl;
  tlmax_pkg::lb_word_t              lb_wr_data;
  tlmax_pkg::lb_word_t              lb_rd_data;
  tlmax_pkg::col_t                  win_col;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= tlmax_pkg::WidthRst;
      height_q    <= tlmax_pkg::HeightRst;
      threshold_q <= tlmax_pkg::ThresholdRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tlmax_pkg::CfgImageWidth: begin
          width_q <= cfg_data_i[tlmax_pkg::WidthBits-1:0];
        end
        tlmax_pkg::CfgImageHeight: begin
          height_q <= cfg_data_i[tlmax_pkg::HeightBits-1:0];
        end
        tlmax_pkg::CfgCornerThreshold: begin
          threshold_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake: the stage moves on unless a held result blocks it.
  assign s1_go      = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign accept     = in_valid_i && !in_stall_o;
  assign emit       = s1_go && (s1_pos_q.x >= tlmax_pkg::ColBits'(2)) &&
                      (s1_pos_q.y >= tlmax_pkg::RowBits'(2));

  tlmax_pos u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .frame_start_i (in_data_i.frame_start),
    .width_i       (width_q),
    .height_i      (height_q),
    .pos_o         (in_pos)
  );

  // Line store access: read for the incoming beat, write back for the stage.
  assign lb_ctrl.rd_en   = accept;
  assign lb_ctrl.rd_addr = in_pos.x;
  assign lb_ctrl.wr_en   = s1_go;
  assign lb_ctrl.wr_addr = s1_pos_q.x;
  assign lb_wr_data.row_a = s1_sample_q;
  assign lb_wr_data.row_b = lb_rd_data.row_a;

  tlmax_lbuf u_lbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (lb_ctrl),
    .wr_data_i (lb_wr_data),
    .rd_data_o (lb_rd_data)
  );

  // Newest window column: rows y-2, y-1 and the current sample.
  assign win_col.top = lb_rd_data.row_b;
  assign win_col.mid = lb_rd_data.row_a;
  assign win_col.bot = s1_sample_q;

  tlmax_nms u_nms (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (s1_go),
    .col_i       (win_col),
    .threshold_i (threshold_q),
    .is_corner_o (is_corner)
  );

  // Processing stage registers.
  assign s1_valid_d = accept || (s1_valid_q && !s1_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pos_q    <= in_pos;
      s1_sample_q <= in_data_i.response_value;
    end
  end

  // Result register: loaded on a decision, cleared once the beat is taken.
  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.centre_x  <= s1_pos_q.x - tlmax_pkg::ColBits'(1);
      out_data_q.centre_y  <= s1_pos_q.y - tlmax_pkg::RowBits'(1);
      out_data_q.is_corner <= is_corner;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An accepted beat always reaches the processing stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted beat did not enter the processing stage");

  // A new result only ever follows a processed beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_go))
    else $error("result appeared without a processed beat");

  // An interior decision is always delivered to the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("interior decision was dropped");

  // Results never name a pixel of the first row or the first column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.centre_x != '0) && (out_data_q.centre_y != '0))
    else $error("result names a border pixel");

endmodule
`default_nettype wire

// File: tb/tb_threshold_local_max_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_threshold_local_max_3x3_core
// Self-checking bench for the thresholded 3x3 local-maximum core. A tracker
// class mirrors the line stores, the window and the raster position and
// predicts one decision per interior pixel. Every result beat is compared
// with the oldest prediction. Both stream sides idle and stall at random,
// and the run steps through several frame geometries and thresholds.
// ----------------------------------------------------------------------------
module tb_threshold_local_max_3x3_core;
  import tlmax_pkg::*;

  // Tracks the pixel stream and predicts the decision for each interior pixel.
  class corner_tracker;
    sample_t                row_above  [MaxWidth];
    sample_t                row_two_up [MaxWidth];
    sample_t                win        [6];
    int unsigned            col_pos;
    int unsigned            row_pos;
    logic [WidthBits-1:0]   width_reg;
    logic [HeightBits-1:0]  height_reg;
    sample_t                thr_reg;
    out_beat_t              pending_decisions [$];
    int unsigned            samples_taken;
    int unsigned            decisions_seen;
    int unsigned            corners_seen;
    int unsigned            mismatches;

    function new();
      width_reg      = WidthRst;
      height_reg     = HeightRst;
      thr_reg        = ThresholdRst;
      col_pos        = 0;
      row_pos        = 0;
      samples_taken  = 0;
      decisions_seen = 0;
      corners_seen   = 0;
      mismatches     = 0;
      foreach (win[i]) win[i] = '0;
      foreach (row_above[i]) begin
        row_above[i]  = '0;
        row_two_up[i] = '0;
      end
    endfunction

    function void set_register(cfg_reg_e idx, logic [CfgDataBits-1:0] value);
      case (idx)
        CfgImageWidth:      width_reg  = value[WidthBits-1:0];
        CfgImageHeight:     height_reg = value[HeightBits-1:0];
        CfgCornerThreshold: thr_reg    = value;
        default: ;
      endcase
    endfunction

    // Out-of-range geometry is clamped to the supported range.
    function int unsigned row_length();
      if (width_reg < WidthMin) return WidthMin;
      if (width_reg > WidthMax) return WidthMax;
      return width_reg;
    endfunction

    function int unsigned frame_rows();
      if (height_reg < HeightMin) return HeightMin;
      if (height_reg > HeightMax) return HeightMax;
      return height_reg;
    endfunction

    // Consume one accepted sample beat and queue its decision, if any.
    function void take_sample(in_beat_t beat);
      sample_t   above2;
      sample_t   above1;
      sample_t   fresh;
      sample_t   centre;
      logic      peak;
      out_beat_t d;
      if (beat.frame_start) begin
        col_pos = 0;
        row_pos = 0;
      end
      above2 = row_two_up[col_pos];
      above1 = row_above[col_pos];
      fresh  = beat.response_value;
      row_two_up[col_pos] = above1;
      row_above[col_pos]  = fresh;

      // The window is complete once two columns and two rows lie behind.
      if (col_pos >= 2 && row_pos >= 2) begin
        centre = win[4];
        peak   = 1'b1;
        for (int k = 0; k < 3; k++) begin
          if (centre < win[k] || centre < win[3+k]) peak = 1'b0;
        end
        if (centre < above2 || centre < above1 || centre < fresh) peak = 1'b0;
        d.centre_x  = ColBits'(col_pos - 1);
        d.centre_y  = RowBits'(row_pos - 1);
        d.is_corner = peak && (centre > thr_reg);
        pending_decisions = {pending_decisions, d};
      end

      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = above2;
      win[4] = above1;
      win[5] = fresh;

      // Raster advance with wrap at the end of a row and of the frame.
      col_pos++;
      if (col_pos >= row_length()) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= frame_rows()) row_pos = 0;
      end
      samples_taken++;
    endfunction

    // Compare one accepted result beat with the oldest prediction.
    function void match_decision(out_beat_t got);
      out_beat_t want;
      if (pending_decisions.size() == 0) begin
        $error("unexpected decision beat: x=%0d y=%0d corner=%0d",
               got.centre_x, got.centre_y, got.is_corner);
        mismatches++;
        return;
      end
      want = pending_decisions.pop_front();
      decisions_seen++;
      if (want.is_corner) corners_seen++;
      if (got.centre_x !== want.centre_x) begin
        $error("centre_x: expected %0d, actual %0d", want.centre_x, got.centre_x);
        mismatches++;
      end
      if (got.centre_y !== want.centre_y) begin
        $error("centre_y: expected %0d, actual %0d", want.centre_y, got.centre_y);
        mismatches++;
      end
      if (got.is_corner !== want.is_corner) begin
        $error("is_corner: expected %0d, actual %0d at x=%0d y=%0d",
               want.is_corner, got.is_corner, want.centre_x, want.centre_y);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we      = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_index   = '0;
  logic [CfgDataBits-1:0] cfg_data    = '0;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  in_beat_t               in_data     = '0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  out_beat_t              out_data;

  corner_tracker nms = new();
  bit          quiet_mode = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned settings_applied = 0;

  threshold_local_max_3x3_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls, quiet stretches and one long hold-off.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 300;
      out_stall <= 1'b1;
    end else if (quiet_mode) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 24);
    end
  end

  // Check every result beat taken at this edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) nms.match_decision(out_data);
  end

  // Mix of extremes, values around the threshold, tie-prone small values
  // and full-range noise.
  function automatic sample_t pick_response();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    if (r == 1) return nms.thr_reg + sample_t'($urandom_range(0, 2)) - sample_t'(1);
    if (r <= 4) begin
      v = int'($urandom_range(0, 8)) - 4;
      return sample_t'(v);
    end
    return sample_t'($urandom());
  endfunction

  task automatic send_sample(input in_beat_t beat);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    nms.take_sample(beat);
  endtask

  // Random idle cycles on the sample side, with junk on the data lines.
  task automatic sample_gaps();
    while (!quiet_mode && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      in_data  <= in_beat_t'($urandom());
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (nms.pending_decisions.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_register(input cfg_reg_e idx, input logic [CfgDataBits-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    nms.set_register(idx, value);
  endtask

  // Bring the core to idle, then load a new geometry and threshold.
  task automatic load_settings(input int w, input int h, input int thr);
    in_valid <= 1'b0;
    wait_drained();
    // Border beats give no result, so allow the pipeline to empty.
    repeat (16) @(posedge clk_i);
    put_register(CfgImageWidth, CfgDataBits'(w));
    put_register(CfgImageHeight, CfgDataBits'(h));
    put_register(CfgCornerThreshold, CfgDataBits'(thr));
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // One frame-aligned stretch of random samples under fresh settings.
  task automatic run_phase(input int w, input int h, input int thr, input int count,
                           input bit quiet, input bit hold, input bit pause_mid);
    in_beat_t beat;
    load_settings(w, h, thr);
    quiet_mode = quiet;
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < count; i++) begin
      beat.response_value = pick_response();
      beat.frame_start    = (i == 0) || ($urandom_range(0, 63) == 0);
      send_sample(beat);
      if (pause_mid && i == count / 2) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        wait_drained();
      end else begin
        sample_gaps();
      end
    end
    quiet_mode = 1'b0;
  endtask

  int directed_px [19] = '{0, 0, 0, -32768,
                           0, 101, 101, 0,
                           5, 100, 7, -32768,
                           100, 32767, -1, 0,
                           3, -3, 9};

  initial begin
    in_beat_t beat;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed 4x4 frame: a tied plateau above the threshold, both sample
    // extremes, a wrap at the end of the frame and a restart mid-row.
    load_settings(4, 4, 100);
    for (int i = 0; i < 19; i++) begin
      beat.response_value = sample_t'(directed_px[i]);
      beat.frame_start    = (i == 0) || (i == 17);
      send_sample(beat);
      sample_gaps();
    end

    run_phase(5, 6, 0, 100, 1'b0, 1'b0, 1'b1);
    run_phase(3, 3, -32768, 40, 1'b0, 1'b0, 1'b0);
    // Width and height below the minimum clamp to three.
    run_phase(1, 0, 32767, 30, 1'b0, 1'b0, 1'b0);
    run_phase(7, 5, int'($urandom_range(0, 65535)), 80, 1'b0, 1'b1, 1'b0);
    // Height above the maximum clamps; run with no idling on either side.
    run_phase(12, 8191, 2212, 60, 1'b1, 1'b0, 1'b0);
    // Width above the maximum clamps to the line store depth.
    run_phase(2047, 4, int'($urandom_range(0, 65535)), 20,
              1'b0, 1'b0, 1'b0);
    for (int p = 0; p < 4; p++) begin
      run_phase(int'($urandom_range(3, 16)), int'($urandom_range(3, 10)),
                int'($urandom_range(0, 65535)), 12, 1'b0, 1'b0, 1'b0);
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (nms.pending_decisions.size() != 0) begin
      $error("%0d predicted decisions never arrived", nms.pending_decisions.size());
      nms.mismatches += nms.pending_decisions.size();
    end

    $display("Covered %0d samples over %0d register settings, clamped geometry included.",
             nms.samples_taken, settings_applied);
    $display("Checked %0d decisions, %0d of them corners.",
             nms.decisions_seen, nms.corners_seen);
    if (nms.mismatches == 0) begin
      $display("tb_threshold_local_max_3x3_core: clean");
    end else begin
      $display("tb_threshold_local_max_3x3_core: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3_000_000;
    $display("tb_threshold_local_max_3x3_core: errors");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tlmax_pkg.sv
hw/rtl/tlmax_pos.sv
hw/rtl/tlmax_lbuf.sv
hw/rtl/tlmax_nms.sv
hw/rtl/threshold_local_max_3x3_core.sv
tb/tb_threshold_local_max_3x3_core.sv
